FILE: rtl/core/pfla_pkg.sv
// Shared constants and types for the page free list allocator.
// Holds command and status codes, field widths and the controller/datapath link types.
// No dependencies.
`default_nettype none

package pfla_pkg;

   // Field widths fixed by the command and response formats
   localparam int OP_W       = 3;
   localparam int DEV_PORT_W = 3;
   localparam int PAGE_BITS  = 24;
   localparam int CAP_W      = PAGE_BITS + 1;
   localparam int GEN_W      = 32;
   localparam int STAT_W     = 2;

   // Default sizing
   localparam int NUM_DEVICES_DEF = 8;
   localparam int FREE_DEPTH_DEF  = 64;

   // Command codes
   localparam logic [OP_W-1:0] OP_REGISTER = 3'd0;
   localparam logic [OP_W-1:0] OP_CLEAR    = 3'd1;
   localparam logic [OP_W-1:0] OP_RELEASE  = 3'd2;
   localparam logic [OP_W-1:0] OP_ALLOCATE = 3'd3;
   localparam logic [OP_W-1:0] OP_QUERY    = 3'd4;

   // Response status codes
   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STAT_W-1:0] ST_EXHAUSTED = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

   // Controller to datapath commands
   typedef struct packed {
      logic load;     // capture command fields
      logic rd_rec;   // read device record
      logic eval;     // execute and write back
      logic pop;      // take popped page from stack read
   } ctrl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic pop_pending;  // stack read issued, page arrives next cycle
   } dpath_stat_type;

endpackage

`default_nettype wire

FILE: rtl/core/pfla_ctrl.sv
// Sequencing controller for the page free list allocator.
// Steps one command through read, execute, optional stack pop and response.
// Depends on pfla_pkg.
`default_nettype none

module pfla_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire pfla_pkg::dpath_stat_type stat,
   output logic                         busy,
   output logic                         rsp_strobe,
   output pfla_pkg::ctrl_cmd_type       cmd
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_READ = 5'b00010,
      S_EVAL = 5'b00100,
      S_POP  = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // Next state and command decode
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      case (state_ff)
         S_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
            if (start) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.rd_rec = 1'b1;
            state_in   = S_EVAL;
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = stat.pop_pending ? S_POP : S_DONE;
         end
         S_POP: begin
            cmd.pop  = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            rsp_strobe = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/pfla_dpath.sv
// Datapath for the page free list allocator: device records, free stack memory, results.
// Record table and stack are single-port memories with registered reads.
// Depends on pfla_pkg.
`default_nettype none

module pfla_dpath #(
   parameter int NUM_DEVICES = pfla_pkg::NUM_DEVICES_DEF,
   parameter int FREE_DEPTH  = pfla_pkg::FREE_DEPTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire pfla_pkg::ctrl_cmd_type            cmd,
   output pfla_pkg::dpath_stat_type               stat,
   input  wire logic [pfla_pkg::OP_W-1:0]         req_operation,
   input  wire logic [pfla_pkg::DEV_PORT_W-1:0]   req_device,
   input  wire logic [pfla_pkg::PAGE_BITS-1:0]    req_page,
   input  wire logic [pfla_pkg::CAP_W-1:0]        req_capacity,
   output logic      [pfla_pkg::STAT_W-1:0]       rsp_status,
   output logic      [pfla_pkg::DEV_PORT_W-1:0]   rsp_device_out,
   output logic      [pfla_pkg::GEN_W-1:0]        rsp_generation,
   output logic      [pfla_pkg::PAGE_BITS-1:0]    rsp_page_out,
   output logic      [pfla_pkg::CAP_W-1:0]        rsp_next_fresh
);

   localparam int DEV_W     = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
   localparam int SLOT_W    = $clog2(FREE_DEPTH);
   localparam int CNT_W     = $clog2(FREE_DEPTH + 1);
   localparam int STK_DEPTH = NUM_DEVICES << SLOT_W;
   localparam int PB        = pfla_pkg::PAGE_BITS;
   localparam int FRESH_W   = pfla_pkg::CAP_W;

   typedef struct packed {
      logic [FRESH_W-1:0]           fresh;
      logic [FRESH_W-1:0]           limit;
      logic [pfla_pkg::GEN_W-1:0]   gen;
      logic [CNT_W-1:0]             count;
   } rec_type;

   // Latched command
   logic [pfla_pkg::OP_W-1:0]       op_ff;
   logic [pfla_pkg::DEV_PORT_W-1:0] dev_ff;
   logic [PB-1:0]                   page_ff;
   logic [FRESH_W-1:0]              cap_ff;

   // Per-device storage
   logic [NUM_DEVICES-1:0] dev_valid_ff;
   rec_type                rec_mem [0:NUM_DEVICES-1];
   rec_type                rec_rd_ff;
   logic                   valid_rd_ff;
   logic [PB-1:0]          stk_mem [0:STK_DEPTH-1];
   logic [PB-1:0]          stk_rd_ff;

   // Result registers
   logic [pfla_pkg::STAT_W-1:0]     stat_ff;
   logic [pfla_pkg::DEV_PORT_W-1:0] dev_out_ff;
   logic [pfla_pkg::GEN_W-1:0]      gen_out_ff;
   logic [PB-1:0]                   page_out_ff;
   logic [FRESH_W-1:0]              nf_ff;

   // Execute-stage signals
   logic [31:0]                     dev_wide;
   logic [DEV_W-1:0]                dev_idx;
   logic                            dev_ok;
   logic                            op_known;
   logic [CNT_W-1:0]                cnt_m1;
   rec_type                         rec_nx;
   logic                            rec_we;
   logic                            valid_set;
   logic                            stk_we;
   logic                            stk_re;
   logic [DEV_W+SLOT_W-1:0]         stk_addr;
   logic [pfla_pkg::STAT_W-1:0]     stat_nx;
   logic [pfla_pkg::DEV_PORT_W-1:0] dev_out_nx;
   logic [pfla_pkg::GEN_W-1:0]      gen_out_nx;
   logic [PB-1:0]                   page_out_nx;
   logic [FRESH_W-1:0]              nf_nx;

   assign dev_wide = 32'(dev_ff);
   assign dev_idx  = dev_wide[DEV_W-1:0];
   assign dev_ok   = dev_wide < 32'(NUM_DEVICES);
   assign op_known = op_ff <= pfla_pkg::OP_QUERY;
   assign cnt_m1   = rec_rd_ff.count - CNT_W'(1);

   // Command capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_operation;
         dev_ff  <= req_device;
         page_ff <= req_page;
         cap_ff  <= req_capacity;
      end
   end

   // Execute: decide status, record update and stack access
   always_comb begin
      rec_nx      = rec_rd_ff;
      rec_we      = 1'b0;
      valid_set   = 1'b0;
      stk_we      = 1'b0;
      stk_re      = 1'b0;
      stk_addr    = {dev_idx, rec_rd_ff.count[SLOT_W-1:0]};
      stat_nx     = pfla_pkg::ST_OK;
      dev_out_nx  = '0;
      gen_out_nx  = '0;
      page_out_nx = '0;
      nf_nx       = '0;
      if (op_known && !dev_ok) begin
         stat_nx = pfla_pkg::ST_NOT_FOUND;
      end else if (op_known && op_ff != pfla_pkg::OP_REGISTER && !valid_rd_ff) begin
         stat_nx = pfla_pkg::ST_NOT_FOUND;
      end else begin
         case (op_ff)
            pfla_pkg::OP_REGISTER: begin
               rec_nx.fresh = {1'b0, page_ff};
               rec_nx.limit = cap_ff;
               rec_nx.gen   = pfla_pkg::GEN_W'(1);
               rec_nx.count = '0;
               rec_we       = 1'b1;
               valid_set    = 1'b1;
            end
            pfla_pkg::OP_CLEAR: begin
               rec_nx.count = '0;
               rec_we       = 1'b1;
            end
            pfla_pkg::OP_RELEASE: begin
               if (rec_rd_ff.count >= CNT_W'(FREE_DEPTH)) begin
                  stat_nx = pfla_pkg::ST_FULL;
               end else begin
                  stk_we       = 1'b1;
                  rec_nx.count = rec_rd_ff.count + CNT_W'(1);
                  rec_we       = 1'b1;
               end
            end
            pfla_pkg::OP_ALLOCATE: begin
               if (rec_rd_ff.count != '0) begin
                  // pop: page arrives from the stack read next cycle
                  stk_re       = 1'b1;
                  stk_addr     = {dev_idx, cnt_m1[SLOT_W-1:0]};
                  rec_nx.count = cnt_m1;
                  rec_nx.gen   = rec_rd_ff.gen + pfla_pkg::GEN_W'(1);
                  rec_we       = 1'b1;
                  dev_out_nx   = dev_ff;
                  gen_out_nx   = rec_rd_ff.gen;
               end else if (rec_rd_ff.fresh < rec_rd_ff.limit && !rec_rd_ff.fresh[PB]) begin
                  // bump allocation
                  rec_nx.fresh = rec_rd_ff.fresh + FRESH_W'(1);
                  rec_nx.gen   = rec_rd_ff.gen + pfla_pkg::GEN_W'(1);
                  rec_we       = 1'b1;
                  dev_out_nx   = dev_ff;
                  gen_out_nx   = rec_rd_ff.gen;
                  page_out_nx  = rec_rd_ff.fresh[PB-1:0];
               end else begin
                  stat_nx = pfla_pkg::ST_EXHAUSTED;
               end
            end
            pfla_pkg::OP_QUERY: begin
               nf_nx = rec_rd_ff.fresh;
            end
            default: begin
               // unknown command: no-op, status ok
            end
         endcase
      end
   end

   // Sampled by the controller in its execute state only
   assign stat.pop_pending = stk_re;

   // Registered flags per device
   always_ff @(posedge clock) begin
      if (reset) begin
         dev_valid_ff <= '0;
      end else if (cmd.eval && valid_set) begin
         dev_valid_ff[dev_idx] <= 1'b1;
      end
   end

   // Device record table
   always_ff @(posedge clock) begin
      if (cmd.eval && rec_we) begin
         rec_mem[dev_idx] <= rec_nx;
      end
      if (cmd.rd_rec) begin
         rec_rd_ff   <= rec_mem[dev_idx];
         valid_rd_ff <= dev_valid_ff[dev_idx] && dev_ok;
      end
   end

   // Free page stacks, one region per device
   always_ff @(posedge clock) begin
      if (cmd.eval && stk_we) begin
         stk_mem[stk_addr] <= page_ff;
      end
      if (cmd.eval && stk_re) begin
         stk_rd_ff <= stk_mem[stk_addr];
      end
   end

   // Result registers
   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         stat_ff     <= stat_nx;
         dev_out_ff  <= dev_out_nx;
         gen_out_ff  <= gen_out_nx;
         page_out_ff <= page_out_nx;
         nf_ff       <= nf_nx;
      end else if (cmd.pop) begin
         page_out_ff <= stk_rd_ff;
      end
   end

   assign rsp_status     = stat_ff;
   assign rsp_device_out = dev_out_ff;
   assign rsp_generation = gen_out_ff;
   assign rsp_page_out   = page_out_ff;
   assign rsp_next_fresh = nf_ff;

endmodule

`default_nettype wire

FILE: rtl/core/page_free_list_allocator.sv
// Per-device page allocator: LIFO free stack in front of a bump pointer.
// The result strobe follows the record read, the execute state and, for a stack pop, the pop state.
// A new command is taken only once the previous one has been answered (busy until the response);
// this is set by the single-port record table (read, then write back) and the stack memory read.
// Reset: synchronous; clears the controller and the per-device registered flags.
// Results are strobed for one cycle; the receiver cannot stall.
`default_nettype none

module page_free_list_allocator #(
   parameter int NUM_DEVICES = pfla_pkg::NUM_DEVICES_DEF,
   parameter int FREE_DEPTH  = pfla_pkg::FREE_DEPTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [pfla_pkg::OP_W-1:0]         req_operation,
   input  wire logic [pfla_pkg::DEV_PORT_W-1:0]   req_device,
   input  wire logic [pfla_pkg::PAGE_BITS-1:0]    req_page,
   input  wire logic [pfla_pkg::CAP_W-1:0]        req_capacity,
   output logic                                   rsp_strobe,
   output logic      [pfla_pkg::STAT_W-1:0]       rsp_status,
   output logic      [pfla_pkg::DEV_PORT_W-1:0]   rsp_device_out,
   output logic      [pfla_pkg::GEN_W-1:0]        rsp_generation,
   output logic      [pfla_pkg::PAGE_BITS-1:0]    rsp_page_out,
   output logic      [pfla_pkg::CAP_W-1:0]        rsp_next_fresh
);

   pfla_pkg::ctrl_cmd_type   cmd;
   pfla_pkg::dpath_stat_type stat;

   // Sequencer
   pfla_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .stat       (stat),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   // Tables, stack and result registers
   pfla_dpath #(
      .NUM_DEVICES (NUM_DEVICES),
      .FREE_DEPTH  (FREE_DEPTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_operation  (req_operation),
      .req_device     (req_device),
      .req_page       (req_page),
      .req_capacity   (req_capacity),
      .rsp_status     (rsp_status),
      .rsp_device_out (rsp_device_out),
      .rsp_generation (rsp_generation),
      .rsp_page_out   (rsp_page_out),
      .rsp_next_fresh (rsp_next_fresh)
   );

`ifndef ASSERT_OFF
   // An accepted command keeps the block busy on the next cycle
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after command transfer");

   // Each command gives one single-cycle response
   a_strobe_single : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe longer than one cycle");

   // Failed commands hand out nothing
   a_fail_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != pfla_pkg::ST_OK) |->
         (rsp_generation == '0 && rsp_page_out == '0 && rsp_device_out == '0))
      else $error("allocation fields set on failed command");
`endif

endmodule

`default_nettype wire

FILE: test/page_free_list_allocator_tb.sv
// Self-checking testbench for the page free list allocator: directed and random commands.
// Predicts each response from its own copy of the per-device tables and free stacks.
// Depends on pfla_pkg and page_free_list_allocator.

module page_free_list_allocator_tb;
   import pfla_pkg::*;

   localparam int RANDOM_COMMANDS = 1950;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int DRAIN_CYCLES    = 10;
   localparam logic [CAP_W-1:0] PAGE_SPAN = {1'b1, {PAGE_BITS{1'b0}}};
   localparam logic [CAP_W-1:0] CAP_MAX   = PAGE_SPAN;

   typedef struct packed {
      logic [STAT_W-1:0]     status;
      logic [DEV_PORT_W-1:0] device;
      logic [GEN_W-1:0]      generation;
      logic [PAGE_BITS-1:0]  page;
      logic [CAP_W-1:0]      next_fresh;
   } alloc_rsp_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic [OP_W-1:0]       req_operation = '0;
   logic [DEV_PORT_W-1:0] req_device = '0;
   logic [PAGE_BITS-1:0]  req_page = '0;
   logic [CAP_W-1:0]      req_capacity = '0;
   logic                  busy;
   logic                  rsp_strobe;
   logic [STAT_W-1:0]     rsp_status;
   logic [DEV_PORT_W-1:0] rsp_device_out;
   logic [GEN_W-1:0]      rsp_generation;
   logic [PAGE_BITS-1:0]  rsp_page_out;
   logic [CAP_W-1:0]      rsp_next_fresh;

   // Predicted per-device state
   logic                 dev_registered [NUM_DEVICES_DEF] = '{default: '0};
   logic [CAP_W-1:0]     fresh_page     [NUM_DEVICES_DEF] = '{default: '0};
   logic [CAP_W-1:0]     dev_limit      [NUM_DEVICES_DEF] = '{default: '0};
   logic [GEN_W-1:0]     dev_generation [NUM_DEVICES_DEF] = '{default: '0};
   logic [6:0]           stack_count    [NUM_DEVICES_DEF] = '{default: '0};
   logic [PAGE_BITS-1:0] free_pages     [NUM_DEVICES_DEF][FREE_DEPTH_DEF];

   alloc_rsp_type pending_responses[$];
   int errors = 0;
   int cycle_count = 0;
   int commands_sent = 0;
   int calm_left = 0;
   int n_served = 0, n_exhausted = 0, n_full = 0, n_not_found = 0, n_unknown = 0;

   page_free_list_allocator DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_operation  (req_operation),
      .req_device     (req_device),
      .req_page       (req_page),
      .req_capacity   (req_capacity),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_device_out (rsp_device_out),
      .rsp_generation (rsp_generation),
      .rsp_page_out   (rsp_page_out),
      .rsp_next_fresh (rsp_next_fresh)
   );

   // Clock: period 10
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   // Response for one accepted command; updates the predicted tables
   function automatic alloc_rsp_type allocator_response(input logic [OP_W-1:0] op,
                                                        input logic [DEV_PORT_W-1:0] dev,
                                                        input logic [PAGE_BITS-1:0] page,
                                                        input logic [CAP_W-1:0] cap);
      alloc_rsp_type rsp;
      logic [6:0] cnt;
      rsp = '0;
      rsp.status = ST_OK;
      if (op > OP_QUERY) begin
         n_unknown++;
      end else if (dev >= NUM_DEVICES_DEF) begin
         rsp.status = ST_NOT_FOUND;
      end else if (op == OP_REGISTER) begin
         dev_registered[dev] = 1'b1;
         fresh_page[dev]     = CAP_W'(page);
         dev_limit[dev]      = cap;
         dev_generation[dev] = GEN_W'(1);
         stack_count[dev]    = '0;
      end else if (!dev_registered[dev]) begin
         rsp.status = ST_NOT_FOUND;
      end else begin
         cnt = stack_count[dev];
         case (op)
            OP_CLEAR: begin
               stack_count[dev] = '0;
            end
            OP_RELEASE: begin
               if (cnt >= FREE_DEPTH_DEF) begin
                  rsp.status = ST_FULL;
               end else begin
                  free_pages[dev][cnt[5:0]] = page;
                  stack_count[dev] = cnt + 7'd1;
               end
            end
            OP_ALLOCATE: begin
               // LIFO stack first, then the bump pointer
               if (cnt > 0) begin
                  rsp.page = free_pages[dev][6'(cnt - 7'd1)];
                  stack_count[dev] = cnt - 7'd1;
               end else if (fresh_page[dev] < dev_limit[dev] &&
                            fresh_page[dev] < PAGE_SPAN) begin
                  rsp.page = fresh_page[dev][PAGE_BITS-1:0];
                  fresh_page[dev] = fresh_page[dev] + CAP_W'(1);
               end else begin
                  rsp.status = ST_EXHAUSTED;
               end
               if (rsp.status == ST_OK) begin
                  rsp.device = dev;
                  rsp.generation = dev_generation[dev];
                  dev_generation[dev] = dev_generation[dev] + GEN_W'(1);
               end
            end
            default: begin
               rsp.next_fresh = fresh_page[dev];
            end
         endcase
      end
      case (rsp.status)
         ST_NOT_FOUND: n_not_found++;
         ST_EXHAUSTED: n_exhausted++;
         ST_FULL:      n_full++;
         default:      if (op == OP_ALLOCATE) n_served++;
      endcase
      return rsp;
   endfunction

   // One command transfer; the prediction is queued at the accepting edge
   task automatic send_command(input logic [OP_W-1:0] op, input logic [DEV_PORT_W-1:0] dev,
                               input logic [PAGE_BITS-1:0] page, input logic [CAP_W-1:0] cap);
      int gap;
      alloc_rsp_type predicted;
      if (calm_left > 0) begin
         gap = 0;
         calm_left--;
      end else begin
         gap = $urandom_range(0, 14);
         if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(10, 40);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_operation <= op;
      req_device    <= dev;
      req_page      <= page;
      req_capacity  <= cap;
      do @(posedge clock); while (busy);
      predicted = allocator_response(op, dev, page, cap);
      pending_responses.insert(pending_responses.size(), predicted);
      commands_sent++;
   endtask

   // Response checker
   always @(posedge clock) begin
      alloc_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_responses.size() == 0) begin
            $error("response with no command outstanding");
            errors++;
         end else begin
            want = pending_responses.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               errors++;
            end
            if (rsp_device_out !== want.device) begin
               $error("device_out: expected %0d, got %0d", want.device, rsp_device_out);
               errors++;
            end
            if (rsp_generation !== want.generation) begin
               $error("generation: expected %0h, got %0h", want.generation, rsp_generation);
               errors++;
            end
            if (rsp_page_out !== want.page) begin
               $error("page_out: expected %0h, got %0h", want.page, rsp_page_out);
               errors++;
            end
            if (rsp_next_fresh !== want.next_fresh) begin
               $error("next_fresh: expected %0h, got %0h", want.next_fresh, rsp_next_fresh);
               errors++;
            end
         end
      end
   end

   // Every operation other than register on slots never registered
   task automatic test_unregistered_slots;
      send_command(OP_QUERY, 3'd3, 24'h000000, 25'h0000000);
      send_command(OP_ALLOCATE, 3'd5, 24'hFFFFFF, CAP_MAX);
      send_command(OP_RELEASE, 3'd7, 24'hFFFFFF, CAP_MAX);
      send_command(OP_CLEAR, 3'd0, 24'h000000, 25'h0000000);
   endtask

   // Codes above query are ignored
   task automatic test_unknown_operations;
      send_command(3'd5, 3'd1, 24'hFFFFFF, CAP_MAX);
      send_command(3'd6, 3'd6, 24'h000000, 25'h0000000);
      send_command(3'd7, 3'd7, 24'h5A5A5A, 25'h0A5A5A5);
   endtask

   // Bump pointer at the top of the page space, zero capacity, capacity below start
   task automatic test_bump_extremes;
      send_command(OP_REGISTER, 3'd7, 24'hFFFFFF, CAP_MAX);
      send_command(OP_ALLOCATE, 3'd7, 24'h000000, 25'h0000000);
      send_command(OP_ALLOCATE, 3'd7, 24'h000000, 25'h0000000);
      send_command(OP_QUERY, 3'd7, 24'h000000, 25'h0000000);
      send_command(OP_REGISTER, 3'd0, 24'h000000, 25'h0000000);
      send_command(OP_ALLOCATE, 3'd0, 24'h000000, 25'h0000000);
      send_command(OP_QUERY, 3'd0, 24'h000000, 25'h0000000);
      send_command(OP_REGISTER, 3'd2, 24'd100, 25'd50);
      send_command(OP_ALLOCATE, 3'd2, 24'h000000, 25'h0000000);
   endtask

   // Stack pops in LIFO order before the bump pointer; clear empties it
   task automatic test_free_stack_lifo;
      send_command(OP_REGISTER, 3'd1, 24'd5, 25'd6);
      send_command(OP_RELEASE, 3'd1, 24'hFFFFFF, 25'h0000000);
      send_command(OP_RELEASE, 3'd1, 24'h000000, 25'h0000000);
      send_command(OP_ALLOCATE, 3'd1, 24'h000000, 25'h0000000);
      send_command(OP_ALLOCATE, 3'd1, 24'h000000, 25'h0000000);
      send_command(OP_ALLOCATE, 3'd1, 24'h000000, 25'h0000000);
      send_command(OP_ALLOCATE, 3'd1, 24'h000000, 25'h0000000);
      send_command(OP_RELEASE, 3'd1, 24'h123456, 25'h0000000);
      send_command(OP_CLEAR, 3'd1, 24'h000000, 25'h0000000);
      send_command(OP_ALLOCATE, 3'd1, 24'h000000, 25'h0000000);
      send_command(OP_QUERY, 3'd1, 24'h000000, 25'h0000000);
   endtask

   // Mixed traffic: mostly release/allocate on random devices, with stack fills
   task automatic test_random_traffic;
      int first, pick, burst, k;
      logic [DEV_PORT_W-1:0] dev;
      logic [PAGE_BITS-1:0]  base;
      logic [CAP_W-1:0]      cap;
      first = commands_sent;
      while (commands_sent - first < RANDOM_COMMANDS) begin
         pick = $urandom_range(0, 99);
         dev  = DEV_PORT_W'($urandom);
         cap  = CAP_W'($urandom_range(0, CAP_MAX));
         if (pick < 4) begin
            // release enough pages to bring one stack near or past its depth, then pop some back
            burst = $urandom_range(FREE_DEPTH_DEF - 4, FREE_DEPTH_DEF + 6);
            for (k = 0; k < burst; k++)
               send_command(OP_RELEASE, dev, PAGE_BITS'($urandom), cap);
            burst = $urandom_range(1, 12);
            for (k = 0; k < burst; k++)
               send_command(OP_ALLOCATE, dev, PAGE_BITS'($urandom), cap);
         end else if (pick < 12) begin
            case ($urandom_range(0, 3))
               0: begin
                  base = PAGE_BITS'($urandom_range(0, 1000));
                  cap  = CAP_W'(base) + CAP_W'($urandom_range(0, 40));
               end
               1: begin
                  base = PAGE_BITS'($urandom);
               end
               2: begin
                  base = 24'hFFFFFF - PAGE_BITS'($urandom_range(0, 20));
                  cap  = CAP_MAX;
               end
               default: begin
                  base = PAGE_BITS'($urandom_range(0, 1000));
                  cap  = CAP_W'($urandom_range(0, base));
               end
            endcase
            send_command(OP_REGISTER, dev, base, cap);
         end else if (pick < 15) begin
            send_command(OP_CLEAR, dev, PAGE_BITS'($urandom), cap);
         end else if (pick < 45) begin
            send_command(OP_RELEASE, dev, PAGE_BITS'($urandom), cap);
         end else if (pick < 85) begin
            send_command(OP_ALLOCATE, dev, PAGE_BITS'($urandom), cap);
         end else if (pick < 95) begin
            send_command(OP_QUERY, dev, PAGE_BITS'($urandom), cap);
         end else begin
            send_command(OP_W'($urandom_range(5, 7)), dev, PAGE_BITS'($urandom), cap);
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_unregistered_slots();
      test_unknown_operations();
      test_bump_extremes();
      test_free_stack_lifo();
      test_random_traffic();
      start <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d commands: %0d pages handed out, %0d exhausted, %0d full-stack drops",
               commands_sent, n_served, n_exhausted, n_full);
      $display("Not-found answers: %0d, ignored unknown operations: %0d",
               n_not_found, n_unknown);
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
